// File: design/srs_pkg.sv
// Shared constants, codes and types of the sparse relaxation sweep.
`timescale 1ns / 1ps

package srs_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 8192;

   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int ROWCOUNT_W = ROW_W + 1;
   localparam int ENTRY_AW   = $clog2(MAX_ENTRIES);
   localparam int COUNT_W    = ENTRY_AW + 1;

   localparam int VALUE_W    = 32;
   localparam int WEIGHT_W   = 18;
   localparam int TOL_W      = 31;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_IDX_W  = 2;

   localparam int MAG_W      = 45;
   localparam int MAG_LO_W   = 27;
   localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
   localparam int DIVIDEND_W = MAG_W + WEIGHT_W;
   localparam int DIVISOR_W  = 32;

   localparam logic signed [63:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] VAL_LIMIT = 64'sh0000_1FFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_RESID  = 3'd2,
      KIND_ORDER  = 3'd3,
      KIND_RUN    = 3'd4,
      KIND_READ   = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIAG = 2'd1,
      STATUS_LOAD = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWEEP_MODE = 2'd0,
      CSR_WEIGHT     = 2'd1,
      CSR_TOLERANCE  = 2'd2,
      CSR_NUM_ROWS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] row_start;
      logic [COUNT_W-1:0] row_end;
   } row_span_type;

endpackage

// File: design/srs_div.sv
// Restoring divider, one quotient bit per cycle, for the correction scaling.
`timescale 1ns / 1ps

module srs_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [srs_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [srs_pkg::DIVISOR_W-1:0]      divisor,
   output logic                               done,
   output logic [srs_pkg::DIVIDEND_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(srs_pkg::DIVIDEND_W);

   logic [srs_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [srs_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [srs_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [srs_pkg::DIVISOR_W:0]    shifted;
   logic [srs_pkg::DIVISOR_W:0]    diff;
   logic                           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[srs_pkg::DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(srs_pkg::DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where the divisor fits
         rem_in = fits ? diff[srs_pkg::DIVISOR_W-1:0] : shifted[srs_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[srs_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/sparse_relaxation_sweep.sv
// Top level of the sparse relaxation sweep: load path, sweep sequencer and state memories.
`timescale 1ns / 1ps

// Sparse relaxation sweep. Items load a row-compressed Q16.16 matrix (appends
// with nondecreasing row), the residual vector and a row visit order, then a
// run item smooths once in Jacobi or Gauss-Seidel mode and a read item returns
// one correction. Load, residual and order items are taken one per cycle when
// the block is idle; a read fetches the correction and posts it. After reset,
// and after every clear item, the row table is wiped, and no item is accepted
// until the wipe ends. A run first wipes the correction memory, then walks the
// visit order through single-port-read memories: per visited row it fetches
// the order entry and row span; per stored entry it reads the entry, and in
// Gauss-Seidel mode also reads the correction, multiplies and accumulates;
// each row then takes the weight multiply and the 63-step divider that scales
// by the diagonal. A run result is posted once the sweep ends, a row lacks a
// usable diagonal or a load error is pending. A result waits in the output
// register while the block goes on accepting items; the next result waits in
// the sequencer until the register is free.

module sparse_relaxation_sweep (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_kind,
   input  logic [srs_pkg::ROW_W-1:0]           req_index,
   input  logic [srs_pkg::ROW_W-1:0]           req_column,
   input  logic signed [srs_pkg::VALUE_W-1:0]  req_value,
   input  logic [srs_pkg::ROW_W-1:0]           req_visit_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [srs_pkg::ROW_W-1:0]           rsp_fail_row,
   output logic signed [srs_pkg::VALUE_W-1:0]  rsp_correction,
   input  logic                                csr_write,
   input  logic [srs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_WAIT,
      S_POST,
      S_VISIT_RD,
      S_VISIT_WAIT,
      S_ROW_WAIT,
      S_ENTRY_RD,
      S_ENTRY_WAIT,
      S_CORR_WAIT,
      S_ACC,
      S_MUL_LO,
      S_MUL_HI,
      S_MUL_SUM,
      S_DIV_WAIT,
      S_WRITE
   } state_type;

   localparam int ROW_W   = srs_pkg::ROW_W;
   localparam int RC_W    = srs_pkg::ROWCOUNT_W;
   localparam int COUNT_W = srs_pkg::COUNT_W;
   localparam int EAW     = srs_pkg::ENTRY_AW;
   localparam int VW      = srs_pkg::VALUE_W;

   // memories
   logic [ROW_W-1:0]              visit_mem [srs_pkg::MAX_ROWS];
   logic [VW-1:0]                 resid_mem [srs_pkg::MAX_ROWS];
   logic [VW-1:0]                 corr_mem  [srs_pkg::MAX_ROWS];
   srs_pkg::row_span_type         row_mem   [srs_pkg::MAX_ROWS];
   logic [ROW_W+VW-1:0]           entry_mem [srs_pkg::MAX_ENTRIES];

   logic [ROW_W-1:0]              visit_q_ff;
   logic signed [VW-1:0]          resid_q_ff;
   logic signed [VW-1:0]          corr_q_ff;
   srs_pkg::row_span_type         row_q_ff;
   logic [ROW_W+VW-1:0]           entry_q_ff;

   logic                          visit_we, resid_we, corr_we, row_we, entry_we;
   logic [ROW_W-1:0]              visit_waddr, resid_waddr, corr_waddr, row_waddr;
   logic [ROW_W-1:0]              visit_wdata, corr_raddr;
   logic [VW-1:0]                 resid_wdata, corr_wdata;
   srs_pkg::row_span_type         row_wdata;
   logic [EAW-1:0]                entry_waddr;
   logic [ROW_W+VW-1:0]           entry_wdata;

   // control and datapath registers
   state_type                     state_ff, state_in;
   logic [RC_W-1:0]               clr_ff, clr_in;
   logic                          clr_rows_ff, clr_rows_in;
   logic                          clr_corr_ff, clr_corr_in;
   logic                          go_sweep_ff, go_sweep_in;
   logic [RC_W-1:0]               i_ff, i_in;
   logic [ROW_W-1:0]              r_ff, r_in;
   logic [COUNT_W-1:0]            j_ff, j_in;
   logic [COUNT_W-1:0]            end_ff, end_in;
   logic signed [63:0]            acc_ff, acc_in;
   logic signed [VW-1:0]          diag_ff, diag_in;
   logic                          found_ff, found_in;
   logic signed [VW-1:0]          a_ff, a_in;
   logic signed [63:0]            prod_ff, prod_in;
   logic [srs_pkg::MAG_W-1:0]     mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [srs_pkg::MAG_W-1:0]     plo_ff, plo_in;
   logic [srs_pkg::MAG_HI_W+srs_pkg::WEIGHT_W-1:0] phi_ff, phi_in;
   logic [1:0]                    post_status_ff, post_status_in;
   logic [ROW_W-1:0]              post_fail_ff, post_fail_in;
   logic [VW-1:0]                 post_corr_ff, post_corr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [ROW_W-1:0]              rsp_fail_ff, rsp_fail_in;
   logic [VW-1:0]                 rsp_corr_ff, rsp_corr_in;
   logic                          mode_ff, mode_in;
   logic [srs_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [srs_pkg::TOL_W-1:0]     tol_ff, tol_in;
   logic [RC_W-1:0]               nrows_ff, nrows_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [COUNT_W-1:0]            start_ff, start_in;
   logic [ROW_W-1:0]              load_row_ff, load_row_in;
   logic                          load_err_ff, load_err_in;

   // helpers
   logic                          accept;
   logic                          rsp_free;
   logic [RC_W-1:0]               rows;
   logic [ROW_W-1:0]              e_col;
   logic signed [VW-1:0]          e_val;
   logic [VW-1:0]                 e_mag;
   logic signed [63:0]            p_mag;
   logic signed [63:0]            p_trunc;
   logic signed [63:0]            acc_step;
   logic signed [63:0]            acc_sat;
   logic signed [63:0]            val_sat;
   logic [srs_pkg::DIVIDEND_W-1:0] num;
   logic [srs_pkg::DIVISOR_W-1:0] diag_mag;
   logic                          div_start;
   logic                          div_done;
   logic [srs_pkg::DIVIDEND_W-1:0] div_q;
   logic                          q_neg;
   logic [VW-1:0]                 q_sat;
   logic                          new_row;
   logic                          append_bad;

   srs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num),
      .divisor  (diag_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rows      = (nrows_ff > RC_W'(srs_pkg::MAX_ROWS)) ? RC_W'(srs_pkg::MAX_ROWS) : nrows_ff;

   assign e_col = entry_q_ff[ROW_W+VW-1:VW];
   assign e_val = entry_q_ff[VW-1:0];
   assign e_mag = e_val[VW-1] ? VW'(-e_val) : VW'(e_val);

   // Gauss-Seidel step: subtract the product truncated toward zero to Q16.16
   assign p_mag    = prod_ff[63] ? -prod_ff : prod_ff;
   assign p_trunc  = {16'b0, p_mag[63:16]};
   assign acc_step = prod_ff[63] ? acc_ff + p_trunc : acc_ff - p_trunc;
   assign acc_sat  = (acc_step > srs_pkg::ACC_LIMIT) ? srs_pkg::ACC_LIMIT :
                     (acc_step < -srs_pkg::ACC_LIMIT) ? -srs_pkg::ACC_LIMIT : acc_step;
   assign val_sat  = (acc_ff > srs_pkg::VAL_LIMIT) ? srs_pkg::VAL_LIMIT :
                     (acc_ff < -srs_pkg::VAL_LIMIT) ? -srs_pkg::VAL_LIMIT : acc_ff;

   assign num = srs_pkg::DIVIDEND_W'(plo_ff)
              + (srs_pkg::DIVIDEND_W'(phi_ff) << srs_pkg::MAG_LO_W);
   assign diag_mag = diag_ff[VW-1] ? srs_pkg::DIVISOR_W'(-diag_ff)
                                   : srs_pkg::DIVISOR_W'(diag_ff);
   assign q_neg = neg_ff ^ diag_ff[VW-1];

   always_comb begin
      if (q_neg) begin
         q_sat = (div_q > srs_pkg::DIVIDEND_W'(33'h0_8000_0000)) ? 32'h8000_0000 : div_q[VW-1:0];
         q_sat = ~q_sat + 1'b1;
      end else begin
         q_sat = (div_q > srs_pkg::DIVIDEND_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[VW-1:0];
      end
   end

   // append checks: store full, or a row below the one being loaded
   assign new_row    = (count_ff == '0) || (req_index != load_row_ff);
   assign append_bad = (count_ff >= COUNT_W'(srs_pkg::MAX_ENTRIES))
                    || ((count_ff != '0) && (req_index < load_row_ff));

   assign corr_raddr = (state_ff == S_ENTRY_WAIT) ? e_col : req_index;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      clr_rows_in    = clr_rows_ff;
      clr_corr_in    = clr_corr_ff;
      go_sweep_in    = go_sweep_ff;
      i_in           = i_ff;
      r_in           = r_ff;
      j_in           = j_ff;
      end_in         = end_ff;
      acc_in         = acc_ff;
      diag_in        = diag_ff;
      found_in       = found_ff;
      a_in           = a_ff;
      prod_in        = prod_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      plo_in         = plo_ff;
      phi_in         = phi_ff;
      post_status_in = post_status_ff;
      post_fail_in   = post_fail_ff;
      post_corr_in   = post_corr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_fail_in    = rsp_fail_ff;
      rsp_corr_in    = rsp_corr_ff;
      count_in       = count_ff;
      start_in       = start_ff;
      load_row_in    = load_row_ff;
      load_err_in    = load_err_ff;
      div_start      = 1'b0;

      visit_we    = 1'b0;
      visit_waddr = req_index;
      visit_wdata = req_visit_row;
      resid_we    = 1'b0;
      resid_waddr = req_index;
      resid_wdata = req_value;
      entry_we    = 1'b0;
      entry_waddr = count_ff[EAW-1:0];
      entry_wdata = {req_column, req_value};
      row_we      = 1'b0;
      row_waddr   = req_index;
      row_wdata   = '{row_start: new_row ? count_ff : start_ff, row_end: count_ff + 1'b1};
      corr_we     = 1'b0;
      corr_waddr  = r_ff;
      corr_wdata  = q_sat;

      mode_in   = mode_ff;
      weight_in = weight_ff;
      tol_in    = tol_ff;
      nrows_in  = nrows_ff;
      if (csr_write) begin
         unique case (csr_index)
            srs_pkg::CSR_SWEEP_MODE: mode_in   = csr_data[0];
            srs_pkg::CSR_WEIGHT:     weight_in = csr_data[srs_pkg::WEIGHT_W-1:0];
            srs_pkg::CSR_TOLERANCE:  tol_in    = csr_data[srs_pkg::TOL_W-1:0];
            srs_pkg::CSR_NUM_ROWS:   nrows_in  = csr_data[RC_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            // wipe the row table and/or corrections, one row a cycle
            row_we     = clr_rows_ff;
            row_waddr  = clr_ff[ROW_W-1:0];
            row_wdata  = '0;
            corr_we    = clr_corr_ff;
            corr_waddr = clr_ff[ROW_W-1:0];
            corr_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == RC_W'(srs_pkg::MAX_ROWS - 1)) begin
               clr_in      = '0;
               clr_rows_in = 1'b0;
               clr_corr_in = 1'b0;
               i_in        = '0;
               state_in    = go_sweep_ff ? S_VISIT_RD : S_IDLE;
               go_sweep_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  srs_pkg::KIND_CLEAR: begin
                     count_in    = '0;
                     load_row_in = '0;
                     load_err_in = 1'b0;
                     clr_in      = '0;
                     clr_rows_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  srs_pkg::KIND_APPEND: begin
                     if (!load_err_ff) begin
                        if (append_bad) begin
                           load_err_in = 1'b1;
                        end else begin
                           entry_we    = 1'b1;
                           row_we      = 1'b1;
                           start_in    = new_row ? count_ff : start_ff;
                           count_in    = count_ff + 1'b1;
                           load_row_in = req_index;
                        end
                     end
                  end
                  srs_pkg::KIND_RESID: resid_we = 1'b1;
                  srs_pkg::KIND_ORDER: visit_we = 1'b1;
                  srs_pkg::KIND_RUN: begin
                     if (load_err_ff) begin
                        post_status_in = srs_pkg::STATUS_LOAD;
                        post_fail_in   = '0;
                        post_corr_in   = '0;
                        state_in       = S_POST;
                     end else begin
                        clr_in      = '0;
                        clr_corr_in = 1'b1;
                        go_sweep_in = 1'b1;
                        state_in    = S_CLEAR;
                     end
                  end
                  srs_pkg::KIND_READ: state_in = S_READ_WAIT;
                  default: ;
               endcase
            end
         end
         S_READ_WAIT: begin
            post_status_in = srs_pkg::STATUS_OK;
            post_fail_in   = '0;
            post_corr_in   = corr_q_ff;
            state_in       = S_POST;
         end
         S_POST: begin
            // hold the result until the output register frees up
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = post_status_ff;
               rsp_fail_in   = post_fail_ff;
               rsp_corr_in   = post_corr_ff;
               state_in      = S_IDLE;
            end
         end
         S_VISIT_RD: begin
            if (i_ff >= rows) begin
               post_status_in = srs_pkg::STATUS_OK;
               post_fail_in   = '0;
               post_corr_in   = '0;
               state_in       = S_POST;
            end else begin
               state_in = S_VISIT_WAIT;
            end
         end
         S_VISIT_WAIT: begin
            // drop visit entries naming a row beyond the rows in use
            if (RC_W'(visit_q_ff) >= rows) begin
               i_in     = i_ff + 1'b1;
               state_in = S_VISIT_RD;
            end else begin
               r_in     = visit_q_ff;
               state_in = S_ROW_WAIT;
            end
         end
         S_ROW_WAIT: begin
            j_in     = row_q_ff.row_start;
            end_in   = row_q_ff.row_end;
            acc_in   = 64'(resid_q_ff);
            diag_in  = '0;
            found_in = 1'b0;
            state_in = S_ENTRY_RD;
         end
         S_ENTRY_RD: begin
            if (j_ff < end_ff) begin
               state_in = S_ENTRY_WAIT;
            end else if (!found_ff) begin
               post_status_in = srs_pkg::STATUS_DIAG;
               post_fail_in   = r_ff;
               post_corr_in   = '0;
               state_in       = S_POST;
            end else begin
               neg_in   = val_sat[63];
               mag_in   = val_sat[63] ? srs_pkg::MAG_W'(-val_sat) : srs_pkg::MAG_W'(val_sat);
               state_in = S_MUL_LO;
            end
         end
         S_ENTRY_WAIT: begin
            a_in = e_val;
            if (e_col == r_ff) begin
               diag_in = e_val;
               if (e_mag >= VW'(tol_ff)) begin
                  found_in = 1'b1;
               end
            end
            if (mode_ff) begin
               state_in = S_CORR_WAIT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_ENTRY_RD;
            end
         end
         S_CORR_WAIT: begin
            prod_in  = a_ff * corr_q_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_sat;
            j_in     = j_ff + 1'b1;
            state_in = S_ENTRY_RD;
         end
         S_MUL_LO: begin
            plo_in   = srs_pkg::MAG_W'(mag_ff[srs_pkg::MAG_LO_W-1:0] * weight_ff);
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            phi_in   = mag_ff[srs_pkg::MAG_W-1:srs_pkg::MAG_LO_W] * weight_ff;
            state_in = S_MUL_SUM;
         end
         S_MUL_SUM: begin
            if (diag_ff == '0) begin
               // zero diagonal: saturate by the sign of the numerator
               corr_we    = 1'b1;
               corr_wdata = (num == '0) ? '0 : (neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF);
               i_in       = i_ff + 1'b1;
               state_in   = S_VISIT_RD;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            corr_we  = 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = S_VISIT_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rows_ff  <= 1'b1;
         clr_corr_ff  <= 1'b1;
         go_sweep_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
         weight_ff    <= srs_pkg::WEIGHT_W'(65536);
         tol_ff       <= '0;
         nrows_ff     <= RC_W'(srs_pkg::MAX_ROWS);
         count_ff     <= '0;
         load_row_ff  <= '0;
         load_err_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rows_ff  <= clr_rows_in;
         clr_corr_ff  <= clr_corr_in;
         go_sweep_ff  <= go_sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         weight_ff    <= weight_in;
         tol_ff       <= tol_in;
         nrows_ff     <= nrows_in;
         count_ff     <= count_in;
         load_row_ff  <= load_row_in;
         load_err_ff  <= load_err_in;
      end
      i_ff           <= i_in;
      r_ff           <= r_in;
      j_ff           <= j_in;
      end_ff         <= end_in;
      acc_ff         <= acc_in;
      diag_ff        <= diag_in;
      found_ff       <= found_in;
      a_ff           <= a_in;
      prod_ff        <= prod_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      plo_ff         <= plo_in;
      phi_ff         <= phi_in;
      post_status_ff <= post_status_in;
      post_fail_ff   <= post_fail_in;
      post_corr_ff   <= post_corr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_fail_ff    <= rsp_fail_in;
      rsp_corr_ff    <= rsp_corr_in;
      start_ff       <= start_in;
   end

   // memory ports: one write, one registered read each
   always_ff @(posedge clock) begin
      if (visit_we) begin
         visit_mem[visit_waddr] <= visit_wdata;
      end
      visit_q_ff <= visit_mem[i_ff[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (resid_we) begin
         resid_mem[resid_waddr] <= resid_wdata;
      end
      resid_q_ff <= resid_mem[visit_q_ff];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_q_ff <= row_mem[visit_q_ff];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      entry_q_ff <= entry_mem[j_ff[EAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (corr_we) begin
         corr_mem[corr_waddr] <= corr_wdata;
      end
      corr_q_ff <= corr_mem[corr_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fail_row   = rsp_fail_ff;
   assign rsp_correction = rsp_corr_ff;

endmodule

// File: design/srs_check.sv
// Port-level checks of the sparse relaxation sweep, bound to the top level.
`timescale 1ns / 1ps

module srs_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [1:0]                          rsp_status,
   input logic [srs_pkg::ROW_W-1:0]           rsp_fail_row,
   input logic signed [srs_pkg::VALUE_W-1:0]  rsp_correction
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == srs_pkg::STATUS_OK || rsp_status == srs_pkg::STATUS_DIAG
                     || rsp_status == srs_pkg::STATUS_LOAD))
      else $error("result status code out of range");

   a_fail_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != srs_pkg::STATUS_DIAG) |-> rsp_fail_row == '0)
      else $error("fail row set on a result without diagonal failure");

   a_run_corr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != srs_pkg::STATUS_OK) |-> rsp_correction == '0)
      else $error("error result carries a correction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_correction)))
      else $error("stalled item dropped or changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sparse_relaxation_sweep srs_check u_srs_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_fail_row   (rsp_fail_row),
   .rsp_correction (rsp_correction)
);
